/* hw/rtl/stw_pkg.sv */
// Station table with aging: shared constants, codes and types.
// No dependencies; imported by every module of the block but stw_ram.
package stw_pkg;

  localparam int STATIONS  = 64;
  localparam int BSS_SLOTS = 8;

  localparam int STA_W    = (STATIONS > 1) ? $clog2(STATIONS) : 1;
  localparam int BSS_W    = (BSS_SLOTS > 1) ? $clog2(BSS_SLOTS) : 1;
  localparam int NB_W     = $clog2(BSS_SLOTS + 1);
  localparam int CNT_W    = STA_W + 1;
  localparam int STAMP_AW = STA_W + BSS_W;

  localparam int ADDR_W   = 48;
  localparam int TIME_W   = 32;
  localparam int TTL_W    = 22;
  localparam int BIU_W    = 4;
  localparam int FUNC_W   = 2;
  localparam int SLOT_W   = 6;
  localparam int BSEL_W   = 3;
  localparam int STATUS_W = 2;
  localparam int FREED_W  = 7;

  localparam int GROUP_BIT = 40;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 22;

  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 16;

  localparam int IN_ADDR_LSB   = 0;
  localparam int IN_CREATE_BIT = 48;
  localparam int IN_NOW_LSB    = 49;
  localparam int IN_SLOT_LSB   = 81;
  localparam int IN_BSEL_LSB   = 87;
  localparam int IN_CONN_BIT   = 90;
  localparam int IN_USED_W     = 91;

  localparam int OUT_IDX_LSB   = 0;
  localparam int OUT_FREED_LSB = 6;
  localparam int OUT_USED_W    = 13;

  localparam logic [TTL_W-1:0] TTL_RESET = TTL_W'(120000);
  localparam logic [BIU_W-1:0] BIU_RESET = BIU_W'(1);

  typedef enum logic [FUNC_W-1:0] {
    FN_LOOKUP = 2'd0,
    FN_EXPIRE = 2'd1,
    FN_SEEN   = 2'd2,
    FN_CONN   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_CREATED = 2'd1,
    ST_NONE    = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STATION_TTL = 1'b0,
    REG_BSS_IN_USE  = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LK_SCAN,
    S_LK_CLR,
    S_EXP_ENTRY,
    S_EXP_RD,
    S_EXP_EVAL,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] key;
    logic [ADDR_W-1:0] entry_addr;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] stamp;
    logic [TTL_W-1:0]  ttl;
  } unit_req_t;

  typedef struct packed {
    logic addr_hit;
    logic key_unicast;
    logic stamp_live;
    logic stamp_aged;
  } unit_rsp_t;

  typedef struct packed {
    logic              we;
    logic [STA_W-1:0]  addr;
    logic [ADDR_W-1:0] data;
  } addr_wr_t;

  typedef struct packed {
    logic                we;
    logic [STAMP_AW-1:0] addr;
    logic [TIME_W-1:0]   data;
  } stamp_wr_t;

endpackage

/* hw/rtl/station_table_with_aging_core.sv */
// Top level of the station table with TTL aging.
// Depends on stw_pkg, stw_ram, stw_unit and stw_seq.
//
// One transaction at a time: in_tready is high only while the sequencer is
// idle, and the result sits in an output register so the next transaction can
// be taken while it waits. Lookup scans the entries through the single read
// port of the address RAM, one entry per cycle, and stops at the first hit;
// when an entry is created, its stamp row is then zeroed one word per cycle.
// Expire walks every entry and, for each examined stamp of a used entry,
// reads the stamp RAM, then does the age compare and write-back in the shared
// unit. No clearing pass is needed after reset.
module station_table_with_aging_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // station_addr[47:0], create[48], now_ms[80:49], slot_sel[86:81],
  // bss_sel[89:87], connected_flag[90], zero[95:91]
  input  logic [stw_pkg::IN_TDATA_W-1:0]     in_tdata,
  // func[1:0]
  input  logic [stw_pkg::FUNC_W-1:0]         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // slot_index[5:0], freed_count[12:6], zero[15:13]
  output logic [stw_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // status[1:0]
  output logic [stw_pkg::STATUS_W-1:0]       out_tuser,
  input  logic                               cfg_wr_en,
  input  logic [stw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [stw_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import stw_pkg::*;

  addr_wr_t            addr_wr;
  logic [STA_W-1:0]    addr_raddr;
  logic [ADDR_W-1:0]   addr_rdata;
  stamp_wr_t           stamp_wr;
  logic [STAMP_AW-1:0] stamp_raddr;
  logic [TIME_W-1:0]   stamp_rdata;
  unit_req_t           unit_req;
  unit_rsp_t           unit_rsp;

  stw_ram #(
    .ADDR_BITS (STA_W),
    .DATA_BITS (ADDR_W)
  ) u_addr_ram (
    .clk   (clk),
    .we    (addr_wr.we),
    .waddr (addr_wr.addr),
    .wdata (addr_wr.data),
    .raddr (addr_raddr),
    .rdata (addr_rdata)
  );

  stw_ram #(
    .ADDR_BITS (STAMP_AW),
    .DATA_BITS (TIME_W)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (stamp_wr.we),
    .waddr (stamp_wr.addr),
    .wdata (stamp_wr.data),
    .raddr (stamp_raddr),
    .rdata (stamp_rdata)
  );

  stw_unit u_unit (
    .req (unit_req),
    .rsp (unit_rsp)
  );

  stw_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .addr_wr     (addr_wr),
    .addr_raddr  (addr_raddr),
    .addr_rdata  (addr_rdata),
    .stamp_wr    (stamp_wr),
    .stamp_raddr (stamp_raddr),
    .stamp_rdata (stamp_rdata),
    .unit_req    (unit_req),
    .unit_rsp    (unit_rsp)
  );

endmodule

/* hw/rtl/stw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stw_ram #(
  parameter int ADDR_BITS = 6,
  parameter int DATA_BITS = 32
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/stw_unit.sv */
// Shared compare unit: address match, unicast test and stamp age check.
// Depends on stw_pkg.
module stw_unit (
  input  stw_pkg::unit_req_t req,
  output stw_pkg::unit_rsp_t rsp
);
  import stw_pkg::*;

  logic [TIME_W-1:0] age;
  logic              live;

  always_comb begin
    age              = req.now - req.stamp;
    live             = (req.stamp != '0);
    rsp.addr_hit     = (req.key == req.entry_addr);
    rsp.key_unicast  = !req.key[GROUP_BIT] && (req.key != '0);
    rsp.stamp_live   = live;
    rsp.stamp_aged   = live && (age >= TIME_W'(req.ttl));
  end

endmodule

/* hw/rtl/stw_seq.sv */
// Sequencer: handshakes, config registers, used/connected bits, table walks.
// Depends on stw_pkg; drives the address RAM, stamp RAM and compare unit.
module stw_seq (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [stw_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic [stw_pkg::FUNC_W-1:0]         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [stw_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [stw_pkg::STATUS_W-1:0]       out_tuser,
  input  logic                               cfg_wr_en,
  input  logic [stw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [stw_pkg::CFG_DATA_W-1:0]     cfg_data,
  output stw_pkg::addr_wr_t                  addr_wr,
  output logic [stw_pkg::STA_W-1:0]          addr_raddr,
  input  logic [stw_pkg::ADDR_W-1:0]         addr_rdata,
  output stw_pkg::stamp_wr_t                 stamp_wr,
  output logic [stw_pkg::STAMP_AW-1:0]       stamp_raddr,
  input  logic [stw_pkg::TIME_W-1:0]         stamp_rdata,
  output stw_pkg::unit_req_t                 unit_req,
  input  stw_pkg::unit_rsp_t                 unit_rsp
);
  import stw_pkg::*;

  state_t              state_r, state_nxt;
  logic [TTL_W-1:0]    ttl_r;
  logic [BIU_W-1:0]    biu_r;
  logic [STATIONS-1:0] used_r, used_nxt;
  logic [STATIONS-1:0] conn_r, conn_nxt;
  logic [ADDR_W-1:0]   key_r, key_nxt;
  logic                create_r, create_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic [CNT_W-1:0]    scan_i_r, scan_i_nxt;
  logic                cmp_v_r, cmp_v_nxt;
  logic [STA_W-1:0]    cmp_i_r, cmp_i_nxt;
  logic                have_free_r, have_free_nxt;
  logic [STA_W-1:0]    free_r, free_nxt;
  logic [BSS_W-1:0]    b_r, b_nxt;
  logic                any_r, any_nxt;
  logic [NB_W-1:0]     nb_r, nb_nxt;
  logic [CNT_W-1:0]    freed_r, freed_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [STA_W-1:0]    res_idx_r, res_idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]   out_idx_r, out_idx_nxt;
  logic [FREED_W-1:0]  out_freed_r, out_freed_nxt;

  func_t             in_func;
  logic [ADDR_W-1:0] in_key;
  logic              in_create;
  logic [TIME_W-1:0] in_now;
  logic [SLOT_W-1:0] in_slot_f;
  logic [BSEL_W-1:0] in_bsel_f;
  logic [STA_W-1:0]  in_slot;
  logic [BSS_W-1:0]  in_bsel;
  logic              in_conn;
  logic              in_slot_ok;
  logic              in_bsel_ok;
  logic [NB_W-1:0]   nb_cfg;
  logic [STA_W-1:0]  cur;
  logic              lk_issue;
  logic              lk_hit;
  logic              lk_create;
  logic              clr_last;
  logic              ent_end;
  logic              exp_last;
  logic              exp_any;
  logic              out_free;

  assign in_func    = func_t'(in_tuser);
  assign in_key     = in_tdata[IN_ADDR_LSB +: ADDR_W];
  assign in_create  = in_tdata[IN_CREATE_BIT];
  assign in_now     = in_tdata[IN_NOW_LSB +: TIME_W];
  assign in_slot_f  = in_tdata[IN_SLOT_LSB +: SLOT_W];
  assign in_bsel_f  = in_tdata[IN_BSEL_LSB +: BSEL_W];
  assign in_conn    = in_tdata[IN_CONN_BIT];
  assign in_slot    = STA_W'(in_slot_f);
  assign in_bsel    = BSS_W'(in_bsel_f);
  assign in_slot_ok = (int'(in_slot_f) < STATIONS);
  assign in_bsel_ok = (int'(in_bsel_f) < BSS_SLOTS);
  assign nb_cfg     = (int'(biu_r) > BSS_SLOTS) ? NB_W'(BSS_SLOTS) : NB_W'(biu_r);

  assign cur        = scan_i_r[STA_W-1:0];
  assign lk_issue   = (scan_i_r != CNT_W'(STATIONS));
  assign lk_hit     = cmp_v_r && used_r[cmp_i_r] && unit_rsp.addr_hit;
  assign lk_create  = create_r && have_free_r && unit_rsp.key_unicast;
  assign clr_last   = (b_r == BSS_W'(BSS_SLOTS - 1));
  assign ent_end    = (scan_i_r == CNT_W'(STATIONS));
  assign exp_last   = ((NB_W'(b_r) + NB_W'(1)) == nb_r);
  assign exp_any    = any_r || (unit_rsp.stamp_live && !unit_rsp.stamp_aged);
  assign out_free   = !out_valid_r || out_tready;

  assign addr_raddr  = cur;
  assign stamp_raddr = {cur, b_r};

  assign unit_req.key        = key_r;
  assign unit_req.entry_addr = addr_rdata;
  assign unit_req.now        = now_r;
  assign unit_req.stamp      = stamp_rdata;
  assign unit_req.ttl        = ttl_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  always_comb begin
    out_tdata = '0;
    out_tdata[OUT_IDX_LSB +: SLOT_W]    = out_idx_r;
    out_tdata[OUT_FREED_LSB +: FREED_W] = out_freed_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          case (in_func)
            FN_LOOKUP: state_nxt = S_LK_SCAN;
            FN_EXPIRE: state_nxt = S_EXP_ENTRY;
            default:   state_nxt = S_RESP;
          endcase
        end
      end
      S_LK_SCAN: begin
        if (lk_hit) begin
          state_nxt = S_RESP;
        end else if (!lk_issue) begin
          state_nxt = lk_create ? S_LK_CLR : S_RESP;
        end
      end
      S_LK_CLR: begin
        if (clr_last) state_nxt = S_RESP;
      end
      S_EXP_ENTRY: begin
        if (ent_end) begin
          state_nxt = S_RESP;
        end else if (used_r[cur] && (nb_r != '0)) begin
          state_nxt = S_EXP_RD;
        end
      end
      S_EXP_RD:   state_nxt = S_EXP_EVAL;
      S_EXP_EVAL: state_nxt = exp_last ? S_EXP_ENTRY : S_EXP_RD;
      S_RESP: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    used_nxt       = used_r;
    conn_nxt       = conn_r;
    key_nxt        = key_r;
    create_nxt     = create_r;
    now_nxt        = now_r;
    scan_i_nxt     = scan_i_r;
    cmp_v_nxt      = cmp_v_r;
    cmp_i_nxt      = cmp_i_r;
    have_free_nxt  = have_free_r;
    free_nxt       = free_r;
    b_nxt          = b_r;
    any_nxt        = any_r;
    nb_nxt         = nb_r;
    freed_nxt      = freed_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_freed_nxt  = out_freed_r;
    addr_wr        = '0;
    stamp_wr       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          key_nxt        = in_key;
          create_nxt     = in_create;
          now_nxt        = in_now;
          scan_i_nxt     = '0;
          cmp_v_nxt      = 1'b0;
          have_free_nxt  = 1'b0;
          nb_nxt         = nb_cfg;
          freed_nxt      = '0;
          res_status_nxt = ST_NONE;
          res_idx_nxt    = '0;
          case (in_func)
            FN_EXPIRE: res_status_nxt = ST_DONE;
            FN_SEEN: begin
              if (in_slot_ok && in_bsel_ok && used_r[in_slot]) begin
                stamp_wr.we    = 1'b1;
                stamp_wr.addr  = {in_slot, in_bsel};
                stamp_wr.data  = in_now;
                res_status_nxt = ST_DONE;
              end
            end
            FN_CONN: begin
              if (in_slot_ok && used_r[in_slot]) begin
                conn_nxt[in_slot] = in_conn;
                res_status_nxt    = ST_DONE;
              end
            end
            default: ;
          endcase
        end
      end
      S_LK_SCAN: begin
        cmp_v_nxt = lk_issue;
        if (lk_issue) begin
          cmp_i_nxt  = cur;
          scan_i_nxt = scan_i_r + CNT_W'(1);
          if (!used_r[cur] && !have_free_r) begin
            have_free_nxt = 1'b1;
            free_nxt      = cur;
          end
        end
        if (lk_hit) begin
          res_status_nxt = ST_DONE;
          res_idx_nxt    = cmp_i_r;
        end else if (!lk_issue && lk_create) begin
          addr_wr.we       = 1'b1;
          addr_wr.addr     = free_r;
          addr_wr.data     = key_r;
          used_nxt[free_r] = 1'b1;
          conn_nxt[free_r] = 1'b0;
          res_status_nxt   = ST_CREATED;
          res_idx_nxt      = free_r;
          b_nxt            = '0;
        end
      end
      S_LK_CLR: begin
        // new entry starts with every stamp unseen
        stamp_wr.we   = 1'b1;
        stamp_wr.addr = {free_r, b_r};
        stamp_wr.data = '0;
        b_nxt         = b_r + BSS_W'(1);
      end
      S_EXP_ENTRY: begin
        if (!ent_end) begin
          if (!used_r[cur]) begin
            scan_i_nxt = scan_i_r + CNT_W'(1);
          end else if (nb_r == '0) begin
            if (!conn_r[cur]) begin
              used_nxt[cur] = 1'b0;
              freed_nxt     = freed_r + CNT_W'(1);
            end
            scan_i_nxt = scan_i_r + CNT_W'(1);
          end else begin
            b_nxt   = '0;
            any_nxt = 1'b0;
          end
        end
      end
      S_EXP_RD: ;
      S_EXP_EVAL: begin
        if (unit_rsp.stamp_aged) begin
          stamp_wr.we   = 1'b1;
          stamp_wr.addr = {cur, b_r};
          stamp_wr.data = '0;
        end
        any_nxt = exp_any;
        if (exp_last) begin
          if (!exp_any && !conn_r[cur]) begin
            used_nxt[cur] = 1'b0;
            freed_nxt     = freed_r + CNT_W'(1);
          end
          scan_i_nxt = scan_i_r + CNT_W'(1);
        end else begin
          b_nxt = b_r + BSS_W'(1);
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_idx_nxt    = SLOT_W'(res_idx_r);
          out_freed_nxt  = FREED_W'(freed_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ttl_r       <= TTL_RESET;
      biu_r       <= BIU_RESET;
      used_r      <= '0;
      conn_r      <= '0;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      conn_r      <= conn_nxt;
      cmp_v_r     <= cmp_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_STATION_TTL: ttl_r <= cfg_data[TTL_W-1:0];
          REG_BSS_IN_USE:  biu_r <= cfg_data[BIU_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    create_r     <= create_nxt;
    now_r        <= now_nxt;
    scan_i_r     <= scan_i_nxt;
    cmp_i_r      <= cmp_i_nxt;
    have_free_r  <= have_free_nxt;
    free_r       <= free_nxt;
    b_r          <= b_nxt;
    any_r        <= any_nxt;
    nb_r         <= nb_nxt;
    freed_r      <= freed_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_freed_r  <= out_freed_nxt;
  end

endmodule

/* hw/rtl/stw_checker.sv */
// Port-level checks for the station table top level, attached by bind.
// Depends on stw_pkg and station_table_with_aging_core.
module stw_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [stw_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [stw_pkg::STATUS_W-1:0]    out_tuser
);
  import stw_pkg::*;

  // result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped before transaction");

  // one transaction at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while previous transaction in progress");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_DONE) || (out_tuser == ST_CREATED) ||
                   (out_tuser == ST_NONE))
    else $error("undefined status");

  a_freed_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[OUT_FREED_LSB +: FREED_W] != '0) |->
      (out_tuser == ST_DONE) && (out_tdata[OUT_IDX_LSB +: SLOT_W] == '0))
    else $error("freed count on a non-expire result");

  a_none_no_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_NONE) |->
      (out_tdata[OUT_IDX_LSB +: SLOT_W] == '0))
    else $error("slot index returned with no entry");

endmodule

bind station_table_with_aging_core stw_checker u_stw_checker (.*);

/* sim/tb_station_table_with_aging_core.sv */
// Self-checking testbench for station_table_with_aging_core: lookups, creates,
// seen stamps, connect flags and TTL expiry against an in-bench table copy.
// Depends on stw_pkg and the RTL of the block; needs nothing else.
module tb_station_table_with_aging_core;
  timeunit 1ns;
  timeprecision 1ps;

  import stw_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int POOL_N      = 96;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 171;

  typedef struct packed {
    func_t             func;
    logic [ADDR_W-1:0] addr;
    logic              create;
    logic [TIME_W-1:0] now;
    logic [SLOT_W-1:0] slot;
    logic [BSEL_W-1:0] bss;
    logic              conn;
  } sta_req_t;

  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  slot_index;
    logic [FREED_W-1:0] freed;
  } sta_rsp_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [FUNC_W-1:0]      in_tuser = FN_LOOKUP;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_STATION_TTL;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // table copy
  logic              sta_used  [STATIONS];
  logic [ADDR_W-1:0] sta_addr  [STATIONS];
  logic              sta_conn  [STATIONS];
  logic [TIME_W-1:0] sta_stamp [STATIONS][BSS_SLOTS];
  logic [TTL_W-1:0]  ttl_cfg = TTL_RESET;
  logic [BIU_W-1:0]  biu_cfg = BIU_RESET;

  sta_req_t request_q[$];
  sta_rsp_t pending_replies[$];
  sta_req_t cur_req;

  logic [ADDR_W-1:0] addr_pool [POOL_N];
  logic [TIME_W-1:0] clock_ms;
  int send_idle = 0;
  int recv_idle = 0;
  int stall_cnt = 0;
  int n_fail = 0;
  int n_items = 0;
  int n_results = 0;
  int n_expire = 0;
  int n_created = 0;
  int n_aged = 0;
  int n_full = 0;

  station_table_with_aging_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  initial begin : init_table
    int i, b;
    for (i = 0; i < STATIONS; i++) begin
      sta_used[i] = 1'b0;
      sta_addr[i] = '0;
      sta_conn[i] = 1'b0;
      for (b = 0; b < BSS_SLOTS; b++) sta_stamp[i][b] = '0;
    end
  end

  function automatic void wipe_station(int i);
    int b;
    sta_used[i] = 1'b0;
    sta_conn[i] = 1'b0;
    for (b = 0; b < BSS_SLOTS; b++) sta_stamp[i][b] = '0;
  endfunction

  function automatic sta_rsp_t table_apply(sta_req_t r);
    sta_rsp_t res;
    logic hit, have_free, any;
    int spare_idx, nb, i, b;
    logic [TIME_W-1:0] age;
    res.status = ST_NONE;
    res.slot_index = '0;
    res.freed = '0;
    case (r.func)
      FN_LOOKUP: begin
        hit = 1'b0;
        have_free = 1'b0;
        spare_idx = 0;
        for (i = 0; i < STATIONS; i++) begin
          if (!hit) begin
            if (sta_used[i] && sta_addr[i] == r.addr) begin
              hit = 1'b1;
              res.slot_index = SLOT_W'(i);
              res.status = ST_DONE;
            end else if (!sta_used[i] && !have_free) begin
              have_free = 1'b1;
              spare_idx = i;
            end
          end
        end
        if (!hit && r.create && !have_free) n_full++;
        // unicast: group bit clear and not the all-zero address
        if (!hit && r.create && have_free && !r.addr[GROUP_BIT] && r.addr != '0) begin
          wipe_station(spare_idx);
          sta_used[spare_idx] = 1'b1;
          sta_addr[spare_idx] = r.addr;
          res.slot_index = SLOT_W'(spare_idx);
          res.status = ST_CREATED;
          n_created++;
        end
      end
      FN_EXPIRE: begin
        nb = (biu_cfg > BSS_SLOTS) ? BSS_SLOTS : int'(biu_cfg);
        for (i = 0; i < STATIONS; i++) begin
          if (sta_used[i]) begin
            any = 1'b0;
            for (b = 0; b < nb; b++) begin
              age = r.now - sta_stamp[i][b];
              if (sta_stamp[i][b] != '0 && age >= TIME_W'(ttl_cfg)) sta_stamp[i][b] = '0;
              if (sta_stamp[i][b] != '0) any = 1'b1;
            end
            if (!any && !sta_conn[i]) begin
              wipe_station(i);
              res.freed = res.freed + 1'b1;
            end
          end
        end
        res.status = ST_DONE;
        n_expire++;
        n_aged += int'(res.freed);
      end
      FN_SEEN: begin
        if (sta_used[r.slot]) begin
          sta_stamp[r.slot][r.bss] = r.now;
          res.status = ST_DONE;
        end
      end
      default: begin
        if (sta_used[r.slot]) begin
          sta_conn[r.slot] = r.conn;
          res.status = ST_DONE;
        end
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : drive_in
    logic [IN_TDATA_W-1:0] d;
    sta_rsp_t r;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        r = table_apply(cur_req);
        pending_replies.push_back(r);
        n_items++;
      end
      if (!in_tvalid || in_tready) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_idle) begin
          cur_req = request_q.pop_front();
          d = '0;
          d[IN_ADDR_LSB +: ADDR_W] = cur_req.addr;
          d[IN_CREATE_BIT]         = cur_req.create;
          d[IN_NOW_LSB +: TIME_W]  = cur_req.now;
          d[IN_SLOT_LSB +: SLOT_W] = cur_req.slot;
          d[IN_BSEL_LSB +: BSEL_W] = cur_req.bss;
          d[IN_CONN_BIT]           = cur_req.conn;
          in_tdata  <= d;
          in_tuser  <= cur_req.func;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_out
    sta_rsp_t e;
    logic [SLOT_W-1:0]  got_idx;
    logic [FREED_W-1:0] got_freed;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
      if (out_tvalid && out_tready) begin
        n_results++;
        got_idx   = out_tdata[OUT_IDX_LSB +: SLOT_W];
        got_freed = out_tdata[OUT_FREED_LSB +: FREED_W];
        if (pending_replies.size() == 0) begin
          $error("unexpected result transaction: status %0d slot_index %0d freed_count %0d",
                 out_tuser, got_idx, got_freed);
          n_fail++;
        end else begin
          e = pending_replies.pop_front();
          if (out_tuser !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_tuser);
            n_fail++;
          end
          if (got_idx !== e.slot_index) begin
            $error("slot_index: expected %0d, got %0d", e.slot_index, got_idx);
            n_fail++;
          end
          if (got_freed !== e.freed) begin
            $error("freed_count: expected %0d, got %0d", e.freed, got_freed);
            n_fail++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (request_q.size() == 0 && pending_replies.size() == 0 && !in_tvalid))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
  end

  initial begin : watchdog
    while (stall_cnt < STALL_LIMIT) @(posedge clk);
    $display("** station_table_with_aging_core: FAILED **");
    $finish;
  end

  task automatic push_req(func_t f, logic [ADDR_W-1:0] a, logic c, logic [TIME_W-1:0] t,
                          logic [SLOT_W-1:0] s, logic [BSEL_W-1:0] b, logic cn);
    sta_req_t r;
    r.func = f;
    r.addr = a;
    r.create = c;
    r.now = t;
    r.slot = s;
    r.bss = b;
    r.conn = cn;
    while (request_q.size() >= 2) @(posedge clk);
    request_q.push_back(r);
  endtask

  task automatic push_random();
    func_t f;
    logic [ADDR_W-1:0] a;
    logic c, cn, found;
    logic [TIME_W-1:0] t;
    logic [SLOT_W-1:0] s;
    int k, base, j;
    a = ADDR_W'({$urandom, $urandom});
    c = 1'($urandom_range(1));
    s = SLOT_W'($urandom_range(STATIONS - 1));
    cn = 1'($urandom_range(1));
    clock_ms = clock_ms + TIME_W'($urandom_range(ttl_cfg / 6 + 20));
    if ($urandom_range(49) == 0) clock_ms = $urandom;
    t = clock_ms;
    k = $urandom_range(99);
    if (k < 48) begin
      f = FN_LOOKUP;
      k = $urandom_range(99);
      if (k < 75) a = addr_pool[$urandom_range(POOL_N - 1)];
      else if (k < 85) a = addr_pool[$urandom_range(POOL_N - 1)] | (48'h1 << GROUP_BIT);
      else if (k < 90) a = '0;
      c = ($urandom_range(99) < 70);
    end else if (k < 56) begin
      f = FN_EXPIRE;
    end else begin
      f = (k < 86) ? FN_SEEN : FN_CONN;
      if ($urandom_range(99) < 85) begin
        base = $urandom_range(STATIONS - 1);
        found = 1'b0;
        for (j = 0; j < STATIONS; j++) begin
          if (!found && sta_used[(base + j) % STATIONS]) begin
            found = 1'b1;
            s = SLOT_W'((base + j) % STATIONS);
          end
        end
      end
      if (f == FN_SEEN && $urandom_range(29) == 0) t = '0;
      if (f == FN_CONN) cn = ($urandom_range(99) < 40);
    end
    push_req(f, a, c, t, s, SLOT_W'($urandom_range(BSS_SLOTS - 1)), cn);
  endtask

  task automatic wait_idle();
    while (request_q.size() != 0 || in_tvalid || pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_STATION_TTL) ttl_cfg = val[TTL_W-1:0];
    else biu_cfg = val[BIU_W-1:0];
  endtask

  initial begin : stim
    logic [ADDR_W-1:0] sta_a, sta_b, sta_c;
    logic [CFG_DATA_W-1:0] ttl_plan [PHASES];
    logic [CFG_DATA_W-1:0] biu_plan [PHASES];
    int p, n;
    sta_a = 48'h0200_1122_3344;
    sta_b = 48'hFEFF_FFFF_FFFF;
    sta_c = 48'h0000_0000_0001;
    for (n = 0; n < POOL_N; n++) begin
      addr_pool[n] = ADDR_W'({$urandom, $urandom});
      addr_pool[n][GROUP_BIT] = 1'b0;
      if (addr_pool[n] == '0) addr_pool[n] = sta_c;
    end
    ttl_plan[0] = 22'd1000;     biu_plan[0] = 22'd8;
    ttl_plan[1] = 22'd3600000;  biu_plan[1] = 22'd0;
    ttl_plan[2] = 22'd0;        biu_plan[2] = 22'd15;
    ttl_plan[3] = CFG_DATA_W'($urandom_range(3600000, 1000));
    biu_plan[3] = 22'h2AAA3;
    ttl_plan[4] = 22'h3FFFFF;   biu_plan[4] = 22'd1;
    ttl_plan[5] = CFG_DATA_W'($urandom_range(20000, 1000));
    biu_plan[5] = CFG_DATA_W'($urandom_range(8));
    clock_ms = $urandom;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    send_idle = 25;
    recv_idle = 68;

    // directed, reset configuration
    push_req(FN_LOOKUP, sta_a, 1'b0, '0, '0, '0, 1'b0);
    push_req(FN_LOOKUP, sta_a, 1'b1, '0, '0, '0, 1'b0);
    push_req(FN_LOOKUP, sta_a, 1'b0, '0, '0, '0, 1'b0);
    push_req(FN_LOOKUP, 48'h0100_0000_0000, 1'b1, '0, '0, '0, 1'b0);
    push_req(FN_LOOKUP, 48'h0, 1'b1, '0, '0, '0, 1'b0);
    push_req(FN_LOOKUP, 48'hFFFF_FFFF_FFFF, 1'b1, '0, '0, '0, 1'b0);
    push_req(FN_LOOKUP, sta_b, 1'b1, '0, '0, '0, 1'b0);
    push_req(FN_SEEN, '0, 1'b0, 32'd1000, 6'd0, 3'd0, 1'b0);
    push_req(FN_SEEN, '0, 1'b0, 32'd0, 6'd1, 3'd7, 1'b0);
    push_req(FN_SEEN, '0, 1'b0, 32'd5, 6'd63, 3'd3, 1'b0);
    push_req(FN_CONN, '0, 1'b0, '0, 6'd1, 3'd0, 1'b1);
    push_req(FN_CONN, '0, 1'b0, '0, 6'd5, 3'd0, 1'b1);
    push_req(FN_EXPIRE, '0, 1'b0, 32'd120999, '0, '0, 1'b0);
    push_req(FN_EXPIRE, '0, 1'b0, 32'd121000, '0, '0, 1'b0);
    push_req(FN_CONN, '0, 1'b0, '0, 6'd1, 3'd0, 1'b0);
    push_req(FN_EXPIRE, '0, 1'b0, 32'd121001, '0, '0, 1'b0);
    push_req(FN_LOOKUP, sta_a, 1'b1, '0, '0, '0, 1'b0);
    push_req(FN_SEEN, '0, 1'b0, 32'hFFFF_FF00, 6'd0, 3'd0, 1'b0);
    push_req(FN_EXPIRE, '0, 1'b0, 32'h0000_0100, '0, '0, 1'b0);
    push_req(FN_LOOKUP, sta_c, 1'b1, '0, '0, '0, 1'b0);
    push_req(FN_LOOKUP, sta_b, 1'b0, '0, '0, '0, 1'b0);
    push_req(FN_LOOKUP, sta_a, 1'b0, '0, '0, '0, 1'b0);
    push_req(FN_SEEN, '0, 1'b0, 32'hFFFF_FFFF, 6'd0, 3'd0, 1'b0);
    push_req(FN_EXPIRE, '0, 1'b0, 32'h0001_D4BF, '0, '0, 1'b0);
    push_req(FN_CONN, '0, 1'b0, '0, 6'd63, 3'd0, 1'b1);

    for (p = 0; p < PHASES; p++) begin
      wait_idle();
      repeat (4) @(posedge clk);
      cfg_write(REG_STATION_TTL, ttl_plan[p]);
      cfg_write(REG_BSS_IN_USE, biu_plan[p]);
      if (p < 2) begin
        send_idle = 25;
        recv_idle = 68;
      end else if (p < 4) begin
        send_idle = 68;
        recv_idle = 25;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (p == 3) clock_ms = 32'hFFF0_0000;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 1 && n == PHASE_ITEMS / 2) wait_idle();
        push_random();
      end
    end

    wait_idle();
    repeat (200) @(posedge clk);
    $display("Run covered %0d transactions in, %0d out, %0d expires over %0d settings",
             n_items, n_results, n_expire, PHASES + 1);
    $display("Stations created %0d, aged out %0d, creates refused on a full table %0d",
             n_created, n_aged, n_full);
    if (n_fail == 0) begin
      $display("** station_table_with_aging_core: PASSED **");
    end else begin
      $display("** station_table_with_aging_core: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/stw_pkg.sv
hw/rtl/stw_ram.sv
hw/rtl/stw_unit.sv
hw/rtl/stw_seq.sv
hw/rtl/station_table_with_aging_core.sv
hw/rtl/stw_checker.sv
sim/tb_station_table_with_aging_core.sv
